// File: rtl/core/assert_macros.svh
// Assertion helpers used by the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is checked on every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Concurrent assertion that a condition never holds outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// File: rtl/core/ffba_pkg.sv
package ffba_pkg;

  // Table and header geometry.
  localparam int MaxBlocks   = 64;
  localparam int HeaderBytes = 24;
  localparam int IdxW        = (MaxBlocks > 1) ? $clog2(MaxBlocks) : 1;
  localparam int CntW        = $clog2(MaxBlocks + 1);

  // Port widths.
  localparam int WordW   = 32;
  localparam int OpW     = 2;
  localparam int StatW   = 3;
  localparam int OutCntW = 13;
  localparam int CfgIdxW = 1;

  // Register reset values.
  localparam logic [WordW-1:0] HeapCapReset = 32'd16777216;
  localparam logic [WordW-1:0] MaxReqReset  = 32'd100000000;

  // Register indexes.
  localparam logic [CfgIdxW-1:0] RegHeapCap = 1'd0;
  localparam logic [CfgIdxW-1:0] RegMaxReq  = 1'd1;

  // Operation codes.
  localparam logic [OpW-1:0] OpAlloc  = 2'd0;
  localparam logic [OpW-1:0] OpFree   = 2'd1;
  localparam logic [OpW-1:0] OpResize = 2'd2;

  // Status codes.
  localparam logic [StatW-1:0] StatOk        = 3'd0;
  localparam logic [StatW-1:0] StatBadSize   = 3'd1;
  localparam logic [StatW-1:0] StatHeapFull  = 3'd2;
  localparam logic [StatW-1:0] StatTableFull = 3'd3;
  localparam logic [StatW-1:0] StatUnknown   = 3'd4;

  // One block table entry.
  typedef struct packed {
    logic [WordW-1:0] size;
    logic [WordW-1:0] start;
    logic             free;
  } entry_t;

endpackage

// File: rtl/core/ffba_ram.sv
module ffba_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/first_fit_block_allocator.sv
// Bad size, free of address 0 and the unused code are answered straight from idle; a free
// or an allocate scans the table once; a resize that must move does two scans and a release.
// Throughput: one command at a time; busy drops in the cycle its result word is strobed,
// so the next command may be taken then. The receiver cannot stall result words.
// Reset clears all counters and the table fill count; table entries need no clearing.
`include "assert_macros.svh"

module first_fit_block_allocator (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [ffba_pkg::OpW-1:0]             operation_i,
  input  logic [ffba_pkg::WordW-1:0]           request_size_i,
  input  logic [ffba_pkg::WordW-1:0]           target_address_i,
  input  logic                                 cfg_we_i,
  input  logic [ffba_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  logic [ffba_pkg::WordW-1:0]           cfg_wdata_i,
  output logic                                 result_valid_o,
  output logic [ffba_pkg::StatW-1:0]           status_o,
  output logic [ffba_pkg::WordW-1:0]           result_address_o,
  output logic [ffba_pkg::OutCntW-1:0]         free_block_count_o,
  output logic [ffba_pkg::WordW-1:0]           free_byte_count_o,
  output logic [ffba_pkg::OutCntW-1:0]         total_block_count_o,
  output logic [ffba_pkg::WordW-1:0]           total_byte_count_o
);

  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StLookup = 2'd1;
  localparam logic [1:0] StAlloc  = 2'd2;
  localparam logic [1:0] StMark   = 2'd3;

  localparam logic [ffba_pkg::CntW-1:0]    CntMax  = ffba_pkg::CntW'(ffba_pkg::MaxBlocks);
  localparam logic [ffba_pkg::WordW-1:0]   HdrWord = ffba_pkg::WordW'(ffba_pkg::HeaderBytes);
  localparam logic [ffba_pkg::WordW+1:0]   HdrWide = (ffba_pkg::WordW + 2)'(ffba_pkg::HeaderBytes);

  logic [1:0]                      state_q, state_d;
  logic [ffba_pkg::WordW-1:0]      cap_q, cap_d, maxreq_q, maxreq_d;
  logic [ffba_pkg::CntW-1:0]       cnt_q, cnt_d, free_blk_q, free_blk_d;
  logic [ffba_pkg::WordW-1:0]      heap_used_q, heap_used_d;
  logic [ffba_pkg::WordW-1:0]      free_bytes_q, free_bytes_d, bytes_q, bytes_d;
  logic [ffba_pkg::CntW-1:0]       ptr_q, ptr_d;
  logic                            chk_vld_q, chk_vld_d;
  logic [ffba_pkg::IdxW-1:0]       chk_idx_q, chk_idx_d;
  logic                            res_vld_q, res_vld_d;
  logic [ffba_pkg::StatW-1:0]      res_status_q, res_status_d;
  logic [ffba_pkg::WordW-1:0]      res_addr_q, res_addr_d;
  logic [ffba_pkg::OpW-1:0]        op_q, op_d;
  logic [ffba_pkg::WordW-1:0]      sz_q, sz_d, tgt_q, tgt_d;
  logic [ffba_pkg::IdxW-1:0]       old_idx_q, old_idx_d;
  ffba_pkg::entry_t                old_ent_q, old_ent_d;

  logic                            ram_we;
  logic [ffba_pkg::IdxW-1:0]       ram_waddr;
  ffba_pkg::entry_t                ram_wdata;
  logic [$bits(ffba_pkg::entry_t)-1:0] ram_rdata;
  ffba_pkg::entry_t                rd_ent;

  logic                            scan_more;
  logic                            in_bad;
  logic                            has_old;
  logic [ffba_pkg::WordW+1:0]      need;

  // Block table: size, start offset and free mark in one word.
  ffba_ram #(
    .Width ($bits(ffba_pkg::entry_t)),
    .Depth (ffba_pkg::MaxBlocks)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ptr_q[ffba_pkg::IdxW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign rd_ent    = ffba_pkg::entry_t'(ram_rdata);
  assign scan_more = (ptr_q < cnt_q);
  assign in_bad    = (request_size_i == '0) || (request_size_i > maxreq_q);
  assign has_old   = (op_q == ffba_pkg::OpResize) && (tgt_q != '0);
  assign need      = {2'b00, heap_used_q} + {2'b00, sz_q} + HdrWide;

  // Sequencer: decode, table scans and table updates.
  always_comb begin
    state_d      = state_q;
    cap_d        = cap_q;
    maxreq_d     = maxreq_q;
    cnt_d        = cnt_q;
    free_blk_d   = free_blk_q;
    heap_used_d  = heap_used_q;
    free_bytes_d = free_bytes_q;
    bytes_d      = bytes_q;
    ptr_d        = ptr_q;
    chk_vld_d    = 1'b0;
    chk_idx_d    = chk_idx_q;
    res_vld_d    = 1'b0;
    res_status_d = res_status_q;
    res_addr_d   = res_addr_q;
    op_d         = op_q;
    sz_d         = sz_q;
    tgt_d        = tgt_q;
    old_idx_d    = old_idx_q;
    old_ent_d    = old_ent_q;
    ram_we       = 1'b0;
    ram_waddr    = chk_idx_q;
    ram_wdata    = rd_ent;

    // Configuration writes must arrive only while idle; the block itself does not enforce this.
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ffba_pkg::RegHeapCap: cap_d    = cfg_wdata_i;
        ffba_pkg::RegMaxReq:  maxreq_d = cfg_wdata_i;
      endcase
    end

    // Both scans issue one table read per cycle; the read data is registered and returns in the next cycle.
    if ((state_q == StLookup) || (state_q == StAlloc)) begin
      if (scan_more) begin
        ptr_d     = ptr_q + 1'b1;
        chk_vld_d = 1'b1;
        chk_idx_d = ptr_q[ffba_pkg::IdxW-1:0];
      end
    end

    unique case (state_q)
      StIdle: begin
        if (start) begin
          op_d  = operation_i;
          sz_d  = request_size_i;
          tgt_d = target_address_i;
          ptr_d = '0;
          chk_vld_d    = 1'b0;
          res_status_d = ffba_pkg::StatOk;
          res_addr_d   = '0;
          unique case (operation_i)
            ffba_pkg::OpAlloc: begin
              if (in_bad) begin
                res_vld_d    = 1'b1;
                res_status_d = ffba_pkg::StatBadSize;
              end else begin
                state_d = StAlloc;
              end
            end
            ffba_pkg::OpFree: begin
              if (target_address_i == '0) begin
                res_vld_d = 1'b1;
              end else begin
                state_d = StLookup;
              end
            end
            ffba_pkg::OpResize: begin
              if (in_bad) begin
                res_vld_d    = 1'b1;
                res_status_d = ffba_pkg::StatBadSize;
              end else if (target_address_i == '0) begin
                state_d = StAlloc;
              end else begin
                state_d = StLookup;
              end
            end
            default: begin
              res_vld_d = 1'b1;
            end
          endcase
        end
      end

      StLookup: begin
        if (chk_vld_q && ((rd_ent.start + HdrWord) == tgt_q)) begin
          if (op_q == ffba_pkg::OpFree) begin
            if (!rd_ent.free) begin
              ram_we         = 1'b1;
              ram_wdata.free = 1'b1;
              free_blk_d     = free_blk_q + 1'b1;
              free_bytes_d   = free_bytes_q + rd_ent.size;
            end
            res_vld_d    = 1'b1;
            res_status_d = ffba_pkg::StatOk;
            res_addr_d   = '0;
            state_d      = StIdle;
          end else if (rd_ent.size >= sz_q) begin
            res_vld_d    = 1'b1;
            res_status_d = ffba_pkg::StatOk;
            res_addr_d   = tgt_q;
            state_d      = StIdle;
          end else begin
            // Too small: remember the old block and look for a new one.
            old_idx_d = chk_idx_q;
            old_ent_d = rd_ent;
            ptr_d     = '0;
            chk_vld_d = 1'b0;
            state_d   = StAlloc;
          end
        end else if (!chk_vld_q && !scan_more) begin
          res_vld_d    = 1'b1;
          res_status_d = ffba_pkg::StatUnknown;
          res_addr_d   = '0;
          state_d      = StIdle;
        end
      end

      StAlloc: begin
        if (chk_vld_q && rd_ent.free && (rd_ent.size >= sz_q)) begin
          // Reuse the first free block that is large enough.
          ram_we         = 1'b1;
          ram_wdata.free = 1'b0;
          free_blk_d     = free_blk_q - 1'b1;
          free_bytes_d   = free_bytes_q - rd_ent.size;
          res_status_d   = ffba_pkg::StatOk;
          res_addr_d     = rd_ent.start + HdrWord;
          chk_vld_d      = 1'b0;
          if (has_old) begin
            state_d = StMark;
          end else begin
            res_vld_d = 1'b1;
            state_d   = StIdle;
          end
        end else if (!chk_vld_q && !scan_more) begin
          if (cnt_q == CntMax) begin
            res_vld_d    = 1'b1;
            res_status_d = ffba_pkg::StatTableFull;
            res_addr_d   = '0;
            state_d      = StIdle;
          end else if (need > {2'b00, cap_q}) begin
            res_vld_d    = 1'b1;
            res_status_d = ffba_pkg::StatHeapFull;
            res_addr_d   = '0;
            state_d      = StIdle;
          end else begin
            // Append a new block at the top of the heap.
            ram_we          = 1'b1;
            ram_waddr       = cnt_q[ffba_pkg::IdxW-1:0];
            ram_wdata.size  = sz_q;
            ram_wdata.start = heap_used_q;
            ram_wdata.free  = 1'b0;
            cnt_d           = cnt_q + 1'b1;
            heap_used_d     = need[ffba_pkg::WordW-1:0];
            bytes_d         = bytes_q + sz_q;
            res_status_d    = ffba_pkg::StatOk;
            res_addr_d      = heap_used_q + HdrWord;
            if (has_old) begin
              state_d = StMark;
            end else begin
              res_vld_d = 1'b1;
              state_d   = StIdle;
            end
          end
        end
      end

      StMark: begin
        // The move succeeded, so the old block is released.
        if (!old_ent_q.free) begin
          ram_we         = 1'b1;
          ram_waddr      = old_idx_q;
          ram_wdata      = old_ent_q;
          ram_wdata.free = 1'b1;
          free_blk_d     = free_blk_q + 1'b1;
          free_bytes_d   = free_bytes_q + old_ent_q.size;
        end
        res_vld_d = 1'b1;
        state_d   = StIdle;
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Control state and counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      cap_q        <= ffba_pkg::HeapCapReset;
      maxreq_q     <= ffba_pkg::MaxReqReset;
      cnt_q        <= '0;
      free_blk_q   <= '0;
      heap_used_q  <= '0;
      free_bytes_q <= '0;
      bytes_q      <= '0;
      ptr_q        <= '0;
      chk_vld_q    <= 1'b0;
      res_vld_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      cap_q        <= cap_d;
      maxreq_q     <= maxreq_d;
      cnt_q        <= cnt_d;
      free_blk_q   <= free_blk_d;
      heap_used_q  <= heap_used_d;
      free_bytes_q <= free_bytes_d;
      bytes_q      <= bytes_d;
      ptr_q        <= ptr_d;
      chk_vld_q    <= chk_vld_d;
      res_vld_q    <= res_vld_d;
    end
  end

  // Command and result words.
  always_ff @(posedge clk_i) begin
    chk_idx_q    <= chk_idx_d;
    res_status_q <= res_status_d;
    res_addr_q   <= res_addr_d;
    op_q         <= op_d;
    sz_q         <= sz_d;
    tgt_q        <= tgt_d;
    old_idx_q    <= old_idx_d;
    old_ent_q    <= old_ent_d;
  end

  assign busy                = (state_q != StIdle);
  assign result_valid_o      = res_vld_q;
  assign status_o            = res_status_q;
  assign result_address_o    = res_addr_q;
  assign free_block_count_o  = ffba_pkg::OutCntW'(free_blk_q);
  assign free_byte_count_o   = free_bytes_q;
  assign total_block_count_o = ffba_pkg::OutCntW'(cnt_q);
  assign total_byte_count_o  = bytes_q;

  `ASSERT_NEVER(a_free_le_total, clk_i, rst_ni, free_blk_q > cnt_q, "free blocks exceed table fill")
  `ASSERT_NEVER(a_cnt_le_max, clk_i, rst_ni, cnt_q > CntMax, "table fill beyond its depth")
  `ASSERT_CLK(a_res_after_cmd, clk_i, rst_ni, result_valid_o |-> ($past(busy) || $past(start)), "result word without a command")
  `ASSERT_CLK(a_lookup_tgt, clk_i, rst_ni, (state_q == StLookup) |-> (tgt_q != '0), "address scan for address zero")

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import ffba_pkg::*;

  // The unused operation code changes nothing; the block answers it with status ok.
  localparam logic [OpW-1:0] OpUnused = 2'd3;

  localparam int unsigned CycleLimit   = 2000000;
  localparam int unsigned SettleCycles = 2 * MaxBlocks + 16;

  // One expected result word.
  typedef struct packed {
    logic [StatW-1:0]   status;
    logic [WordW-1:0]   addr;
    logic [OutCntW-1:0] free_blocks;
    logic [WordW-1:0]   free_bytes;
    logic [OutCntW-1:0] total_blocks;
    logic [WordW-1:0]   total_bytes;
  } outcome_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start;
  logic                 busy;
  logic [OpW-1:0]       operation_i;
  logic [WordW-1:0]     request_size_i;
  logic [WordW-1:0]     target_address_i;
  logic                 cfg_we_i;
  logic [CfgIdxW-1:0]   cfg_idx_i;
  logic [WordW-1:0]     cfg_wdata_i;
  logic                 result_valid_o;
  logic [StatW-1:0]     status_o;
  logic [WordW-1:0]     result_address_o;
  logic [OutCntW-1:0]   free_block_count_o;
  logic [WordW-1:0]     free_byte_count_o;
  logic [OutCntW-1:0]   total_block_count_o;
  logic [WordW-1:0]     total_byte_count_o;

  // Allocator image kept by the testbench.
  logic [WordW-1:0]     heap_cap_reg = HeapCapReset;
  logic [WordW-1:0]     max_req_reg  = MaxReqReset;
  logic [WordW-1:0]     blk_size  [MaxBlocks];
  logic [WordW-1:0]     blk_start [MaxBlocks];
  bit                   blk_free  [MaxBlocks];
  logic [OutCntW-1:0]   blk_count     = '0;
  logic [WordW-1:0]     heap_top      = '0;
  logic [OutCntW-1:0]   free_blk_cnt  = '0;
  logic [WordW-1:0]     free_byte_cnt = '0;
  logic [WordW-1:0]     byte_cnt      = '0;

  outcome_t             pending_outcomes[$];
  int unsigned          n_errors  = 0;
  int unsigned          n_words   = 0;
  int unsigned          n_checked = 0;
  int unsigned          n_cycles  = 0;
  int unsigned          status_seen[5] = '{default: 0};
  bit                   start_hi = 1'b0;
  bit                   sender_idles = 1'b1;

  first_fit_block_allocator u_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .start               (start),
    .busy                (busy),
    .operation_i         (operation_i),
    .request_size_i      (request_size_i),
    .target_address_i    (target_address_i),
    .cfg_we_i            (cfg_we_i),
    .cfg_idx_i           (cfg_idx_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .result_valid_o      (result_valid_o),
    .status_o            (status_o),
    .result_address_o    (result_address_o),
    .free_block_count_o  (free_block_count_o),
    .free_byte_count_o   (free_byte_count_o),
    .total_block_count_o (total_block_count_o),
    .total_byte_count_o  (total_byte_count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Table index of the block whose payload starts at addr, or -1.
  function automatic int find_block(logic [WordW-1:0] addr);
    for (int i = 0; i < int'(blk_count); i++) begin
      if (blk_start[i] + WordW'(HeaderBytes) == addr) return i;
    end
    return -1;
  endfunction

  // First-fit reuse of a free block, else append at the heap top.
  function automatic logic [StatW-1:0] claim_block(input logic [WordW-1:0] size,
                                                   output logic [WordW-1:0] addr);
    logic [WordW+1:0] need;
    logic [IdxW-1:0]  slot;
    addr = '0;
    for (int i = 0; i < int'(blk_count); i++) begin
      if (blk_free[i] && blk_size[i] >= size) begin
        blk_free[i]   = 1'b0;
        free_blk_cnt  = free_blk_cnt - 1'b1;
        free_byte_cnt = free_byte_cnt - blk_size[i];
        addr          = blk_start[i] + WordW'(HeaderBytes);
        return StatOk;
      end
    end
    if (blk_count >= MaxBlocks) return StatTableFull;
    // The heap check must not wrap at 32 bits.
    need = {2'b00, heap_top} + {2'b00, size} + (WordW+2)'(HeaderBytes);
    if (need > {2'b00, heap_cap_reg}) return StatHeapFull;
    slot             = blk_count[IdxW-1:0];
    blk_size[slot]   = size;
    blk_start[slot]  = heap_top;
    blk_free[slot]   = 1'b0;
    addr             = heap_top + WordW'(HeaderBytes);
    blk_count        = blk_count + 1'b1;
    heap_top         = need[WordW-1:0];
    byte_cnt         = byte_cnt + size;
    return StatOk;
  endfunction

  // Marking an already free block again changes nothing.
  function automatic void release_block(int idx);
    if (!blk_free[idx]) begin
      blk_free[idx] = 1'b1;
      free_blk_cnt  = free_blk_cnt + 1'b1;
      free_byte_cnt = free_byte_cnt + blk_size[idx];
    end
  endfunction

  // Applies one request word to the image and returns the result word it gives.
  function automatic outcome_t apply_request(logic [OpW-1:0] op, logic [WordW-1:0] size,
                                             logic [WordW-1:0] tgt);
    outcome_t         o;
    int               idx;
    logic [StatW-1:0] st;
    logic [WordW-1:0] addr;
    bit               bad_size;
    st       = StatOk;
    addr     = '0;
    bad_size = (size == '0) || (size > max_req_reg);
    case (op)
      OpAlloc: begin
        if (bad_size) st = StatBadSize;
        else st = claim_block(size, addr);
      end
      OpFree: begin
        if (tgt != '0) begin
          idx = find_block(tgt);
          if (idx < 0) st = StatUnknown;
          else release_block(idx);
        end
      end
      OpResize: begin
        // Size is checked before the address; address 0 acts as a plain allocate.
        if (bad_size) begin
          st = StatBadSize;
        end else if (tgt == '0) begin
          st = claim_block(size, addr);
        end else begin
          idx = find_block(tgt);
          if (idx < 0) begin
            st = StatUnknown;
          end else if (blk_size[idx] >= size) begin
            addr = tgt;
          end else begin
            st = claim_block(size, addr);
            if (st == StatOk) release_block(idx);
          end
        end
      end
      default: ;
    endcase
    if (st != StatOk) addr = '0;
    status_seen[st]++;
    o.status       = st;
    o.addr         = addr;
    o.free_blocks  = free_blk_cnt;
    o.free_bytes   = free_byte_cnt;
    o.total_blocks = blk_count;
    o.total_bytes  = byte_cnt;
    return o;
  endfunction

  // Sender gaps: mostly short, a few long, none at all while idling is off.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (!sender_idles) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Request sizes: mostly small so that reuse is common, plus the size limits.
  function automatic logic [WordW-1:0] pick_size(int unsigned size_hi);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 76) return WordW'($urandom_range(1, size_hi));
    if (r < 80) return '0;
    if (r < 84) return max_req_reg;
    if (r < 88) return max_req_reg + 1'b1;
    return WordW'($urandom);
  endfunction

  // Targets: mostly a live block, sometimes none, near misses or noise.
  function automatic logic [WordW-1:0] pick_target();
    int unsigned      r;
    logic [WordW-1:0] live;
    r = $urandom_range(0, 99);
    live = '0;
    if (blk_count != '0) begin
      live = blk_start[$urandom_range(0, int'(blk_count) - 1)] + WordW'(HeaderBytes);
    end
    if (r < 70) return live;
    if (r < 80) return '0;
    if (r < 90) return live + WordW'($urandom_range(1, 8));
    return WordW'($urandom);
  endfunction

  // Presents one request word, waits for it to be taken and records its result.
  task automatic send_word(input logic [OpW-1:0] op, input logic [WordW-1:0] size,
                           input logic [WordW-1:0] tgt, output logic [WordW-1:0] granted);
    outcome_t    o;
    int unsigned gap;
    start            <= 1'b1;
    operation_i      <= op;
    request_size_i   <= size;
    target_address_i <= tgt;
    start_hi = 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    o = apply_request(op, size, tgt);
    pending_outcomes.push_back(o);
    granted = o.addr;
    n_words++;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      start_hi = 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Stops sending and waits until every result word has come back.
  task automatic drain();
    if (start_hi) begin
      start <= 1'b0;
      start_hi = 1'b0;
    end
    while (pending_outcomes.size() != 0) @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  // Register writes happen only with the block idle.
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [WordW-1:0] value);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    if (idx == RegHeapCap) heap_cap_reg = value;
    else max_req_reg = value;
  endtask

  task automatic run_random(int unsigned count, int unsigned size_hi);
    logic [OpW-1:0]   op;
    logic [WordW-1:0] granted;
    int unsigned      r;
    for (int k = 0; k < int'(count); k++) begin
      r = $urandom_range(0, 99);
      if (r < 35) op = OpAlloc;
      else if (r < 65) op = OpFree;
      else if (r < 95) op = OpResize;
      else op = OpUnused;
      send_word(op, pick_size(size_hi), pick_target(), granted);
    end
  endtask

  // Every operation and special case from an empty table at the reset settings.
  task automatic test_basic_ops();
    logic [WordW-1:0] a0, a1, a2, a3, dummy;
    send_word(OpUnused, 32'd5, 32'd0, dummy);
    send_word(OpFree, 32'd0, 32'd0, dummy);
    send_word(OpFree, 32'd0, 32'h0000_1234, dummy);
    send_word(OpAlloc, 32'd0, 32'd0, dummy);
    send_word(OpAlloc, max_req_reg + 1'b1, 32'd0, dummy);
    send_word(OpAlloc, 32'hFFFF_FFFF, 32'hFFFF_FFFF, dummy);
    send_word(OpAlloc, max_req_reg, 32'd0, dummy);
    send_word(OpResize, 32'd0, 32'd0, dummy);
    send_word(OpResize, 32'd0, 32'h0000_0777, dummy);
    send_word(OpAlloc, 32'd100, 32'd0, a0);
    send_word(OpResize, 32'd40, 32'd0, a1);
    // Shrinking keeps the address; growing moves and frees the old block.
    send_word(OpResize, 32'd50, a0, dummy);
    send_word(OpResize, 32'd200, a0, a2);
    send_word(OpAlloc, 32'd80, 32'd0, dummy);
    // Free twice, then resize the free block in place and out of place.
    send_word(OpFree, 32'd0, a1, dummy);
    send_word(OpFree, 32'd0, a1, dummy);
    send_word(OpResize, 32'd30, a1, dummy);
    send_word(OpResize, 32'd60, a1, a3);
    // A large resize that fits the heap moves the block and frees the old one.
    send_word(OpResize, 32'd16000000, a3, dummy);
    send_word(OpResize, 32'd10, 32'h0000_0005, dummy);
    send_word(OpFree, 32'd0, a3, dummy);
    send_word(OpAlloc, 32'd20, 32'd0, dummy);
    send_word(OpFree, 32'd0, a2, dummy);
    drain();
  endtask

  // Both registers at their extremes and the heap check at its exact boundary.
  task automatic test_register_extremes();
    logic [WordW-1:0] dummy;
    write_reg(RegMaxReq, 32'd1);
    send_word(OpAlloc, 32'd1, 32'd0, dummy);
    send_word(OpAlloc, 32'd2, 32'd0, dummy);
    send_word(OpResize, 32'd2, 32'd0, dummy);
    write_reg(RegMaxReq, 32'hFFFF_FFFF);
    send_word(OpAlloc, 32'hFFFF_FFFF, 32'd0, dummy);
    write_reg(RegHeapCap, 32'd0);
    send_word(OpAlloc, 32'd30, 32'd0, dummy);
    send_word(OpAlloc, 32'd5000, 32'd0, dummy);
    write_reg(RegHeapCap, heap_top + WordW'(HeaderBytes) + 32'd5000);
    send_word(OpAlloc, 32'd5000, 32'd0, dummy);
    send_word(OpAlloc, 32'd6000, 32'd0, dummy);
    write_reg(RegHeapCap, 32'hFFFF_FFFF);
    send_word(OpAlloc, 32'hFFFF_FFFF, 32'd0, dummy);
    send_word(OpAlloc, 32'hFFFF_FFFF - heap_top - WordW'(HeaderBytes) + 1'b1, 32'd0, dummy);
    write_reg(RegHeapCap, HeapCapReset);
    write_reg(RegMaxReq, MaxReqReset);
  endtask

  // A small heap so that exhaustion comes well before the table fills.
  task automatic test_tight_heap();
    write_reg(RegHeapCap, heap_top + 32'd2500);
    write_reg(RegMaxReq, 32'd200);
    sender_idles = 1'b1;
    run_random(450, 64);
    drain();
  endtask

  // A heap cap at its maximum so that the table fills; first back to back, then with gaps.
  task automatic test_table_fill();
    write_reg(RegHeapCap, 32'hFFFF_FFFF);
    write_reg(RegMaxReq, 32'd100000);
    sender_idles = 1'b0;
    run_random(450, 128);
    sender_idles = 1'b1;
    run_random(450, 128);
    drain();
  endtask

  // Reuse, free and resize traffic on a full table at the reset settings.
  task automatic test_reuse_mix();
    write_reg(RegHeapCap, HeapCapReset);
    write_reg(RegMaxReq, MaxReqReset);
    run_random(450, 256);
    drain();
  endtask

  function automatic void check_field(string name, logic [WordW-1:0] want,
                                      logic [WordW-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      n_errors++;
    end
  endfunction

  // Each result word is compared with the oldest expected one.
  always @(posedge clk_i) begin : check_results
    outcome_t want;
    if (rst_ni && result_valid_o) begin
      if (pending_outcomes.size() == 0) begin
        $display("%0t: unexpected result word: expected none, actual status %0d address %0h",
                 $time, status_o, result_address_o);
        n_errors++;
      end else begin
        want = pending_outcomes.pop_front();
        n_checked++;
        check_field("status", WordW'(want.status), WordW'(status_o));
        check_field("result_address", want.addr, result_address_o);
        check_field("free_block_count", WordW'(want.free_blocks),
                    WordW'(free_block_count_o));
        check_field("free_byte_count", want.free_bytes, free_byte_count_o);
        check_field("total_block_count", WordW'(want.total_blocks),
                    WordW'(total_block_count_o));
        check_field("total_byte_count", want.total_bytes, total_byte_count_o);
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles > CycleLimit) begin
      $display("%0t: timeout with %0d result words outstanding", $time,
               pending_outcomes.size());
      $display("** first_fit_block_allocator: FAILED **");
      $finish;
    end
  end

  initial begin
    rst_ni           <= 1'b0;
    start            <= 1'b0;
    operation_i      <= OpAlloc;
    request_size_i   <= '0;
    target_address_i <= '0;
    cfg_we_i         <= 1'b0;
    cfg_idx_i        <= RegHeapCap;
    cfg_wdata_i      <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_basic_ops();
    test_register_extremes();
    test_tight_heap();
    test_table_fill();
    test_reuse_mix();

    drain();
    repeat (SettleCycles) @(posedge clk_i);

    $display("Sent %0d request words, checked %0d result words, %0d blocks in the table.",
             n_words, n_checked, blk_count);
    $display("Statuses: ok %0d, bad size %0d, heap full %0d, table full %0d, unknown %0d.",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4]);
    if (n_errors == 0) begin
      $display("** first_fit_block_allocator: PASSED **");
    end else begin
      $display("** first_fit_block_allocator: FAILED **");
    end
    $finish;
  end

endmodule
